// ===== design/servo_bus_packet_framer_assert.svh =====
// Assertion macros for the servo bus packet framer.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef SERVO_BUS_PACKET_FRAMER_ASSERT_SVH
`define SERVO_BUS_PACKET_FRAMER_ASSERT_SVH

// same-cycle implication
`define SBPF_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBPF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sbpf_pkg.sv =====
// Shared types and constants of the servo bus packet framer.
// No dependencies.
`default_nettype none

package sbpf_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;    // lengths and counters; read lengths saturate at 127
   localparam int FIX_N  = 7;    // header part of a packet
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [BYTE_W-1:0] SPEED_CMD_A = 8'h05;
   localparam logic [BYTE_W-1:0] SPEED_CMD_B = 8'h06;
   localparam logic [LEN_W-1:0]  STATUS_LEN  = 7'd9;
   localparam logic [8:0]        READ_EXTRA  = 9'd11;
   localparam logic [LEN_W-1:0]  LEN_SAT     = 7'd127;

   typedef enum logic [1:0] {
      OP_REQ   = 2'd0,
      OP_BUS   = 2'd1,
      OP_ABORT = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_SEND   = 2'd0,
      KIND_ANSWER = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_SPEED      = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_BAD_SUM    = 3'd3,
      ST_TOO_LONG   = 3'd4,
      ST_ABORTED    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      REG_HEADER = 3'd0,
      REG_MASK   = 3'd1,
      REG_EEPROM = 3'd2,
      REG_RAM    = 3'd3,
      REG_STATUS = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [BYTE_W-1:0] check_mask;
      logic [BYTE_W-1:0] eeprom_read_code;
      logic [BYTE_W-1:0] ram_read_code;
      logic [BYTE_W-1:0] status_code;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic hdr_fail;
      logic scan_init;
      logic scan_step;
      logic sum_fail;
      logic emit_ans;
      logic emit_load;
      logic stat_load;
   } cmd_type;

   typedef struct packed {
      logic go_stat;
      logic go_emit;
      logic go_achk;
      logic hdr_ok;
      logic scan_done;
      logic sum_ok;
      logic emit_final;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/servo_bus_packet_framer.sv =====
// Servo bus packet framer and answer checker (top level).
// Request channel (req_*): one transaction per byte; req_operation selects request byte,
//   received bus byte, abort of the pending wait, or clear all.
// Result channel (rsp_*): bus bytes to send, answer bytes to the host, or one status event;
//   rsp_last_res marks the final result of a run.
// Config (csr_*): five 8-bit registers at byte addresses 0,4,8,12,16; pready is tied high.
// Sequence: a transaction that yields nothing leaves the block idle. A final request byte
//   starts its packet of 7 + n bytes (n data bytes) and sends each byte by a register
//   fetch and a store read. A completed answer first scans the answer store
//   one byte per cycle for the checksum, then emits its bytes the same way. A status
//   event is loaded after a refused request, an abort, an overlong answer, a bad
//   header, or the end of the checksum scan for a bad checksum.
// Only one transaction is in work at a time; req_stall stays high until its last result
//   sits in the output register, so the next one can enter while that result waits.
// Stall on rsp: the output register holds its transaction and the sequencer waits.
// Reset (synchronous): length ring empty, counters zero, registers at defaults;
//   the byte stores are not cleared.
// Depends on sbpf_pkg, sbpf_csr, sbpf_ctrl, sbpf_datapath and the assertion header.
`default_nettype none
`include "servo_bus_packet_framer_assert.svh"

module servo_bus_packet_framer #(
   parameter int MAX_PACKET  = 64,
   parameter int QUEUE_DEPTH = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [sbpf_pkg::BYTE_W-1:0]  req_value,
   input  logic                         req_last,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [sbpf_pkg::BYTE_W-1:0]  rsp_data,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_last_res,
   output logic                         rsp_answer_pending,
   // configuration port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sbpf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sbpf_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sbpf_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import sbpf_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   sbpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: idle/accept, header check, checksum scan, fetch/emit, status
   sbpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stores, length ring, checksum accumulator and output register
   sbpf_datapath #(
      .MAX_PACKET  (MAX_PACKET),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data           (rsp_data),
      .rsp_status         (rsp_status),
      .rsp_last_res       (rsp_last_res),
      .rsp_answer_pending (rsp_answer_pending)
   );

   // status events always close a run
   `SBPF_ASSERT_SAME(a_status_last, rsp_valid && (rsp_kind == KIND_STATUS), rsp_last_res, "status event without last_res")
   // byte results carry ok status
   `SBPF_ASSERT_SAME(a_byte_ok, rsp_valid && (rsp_kind != KIND_STATUS), (rsp_status == ST_OK), "byte result with nonzero status")
   // a clear-all transaction yields nothing, so the block is ready again at once
   `SBPF_ASSERT_NEXT(a_clear_idle, req_valid && !req_stall && (req_operation == OP_CLEAR), !req_stall, "busy after clear")

endmodule

`default_nettype wire

// ===== design/sbpf_csr.sv =====
// Configuration registers with an APB-style access port.
// Depends on sbpf_pkg.
`default_nettype none

module sbpf_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sbpf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sbpf_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sbpf_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output sbpf_pkg::cfg_type            cfg
);
   import sbpf_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_HEADER: cfg_in.header_byte      = csr_pwdata[BYTE_W-1:0];
            REG_MASK:   cfg_in.check_mask       = csr_pwdata[BYTE_W-1:0];
            REG_EEPROM: cfg_in.eeprom_read_code = csr_pwdata[BYTE_W-1:0];
            REG_RAM:    cfg_in.ram_read_code    = csr_pwdata[BYTE_W-1:0];
            REG_STATUS: cfg_in.status_code      = csr_pwdata[BYTE_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte      <= 8'd255;
         cfg_ff.check_mask       <= 8'd254;
         cfg_ff.eeprom_read_code <= 8'd2;
         cfg_ff.ram_read_code    <= 8'd4;
         cfg_ff.status_code      <= 8'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_HEADER: csr_prdata[BYTE_W-1:0] = cfg_ff.header_byte;
         REG_MASK:   csr_prdata[BYTE_W-1:0] = cfg_ff.check_mask;
         REG_EEPROM: csr_prdata[BYTE_W-1:0] = cfg_ff.eeprom_read_code;
         REG_RAM:    csr_prdata[BYTE_W-1:0] = cfg_ff.ram_read_code;
         REG_STATUS: csr_prdata[BYTE_W-1:0] = cfg_ff.status_code;
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

// ===== design/sbpf_ctrl.sv =====
// Controller state machine: sequences accept, answer check and emission.
// Depends on sbpf_pkg.
`default_nettype none

module sbpf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbpf_pkg::sts_type sts,
   output sbpf_pkg::cmd_type cmd
);
   import sbpf_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ACHK  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_AVER  = 7'b0001000,
      S_FETCH = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_STAT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               priority if (sts.go_stat) state_in = S_STAT;
               else if (sts.go_emit)     state_in = S_FETCH;
               else if (sts.go_achk)     state_in = S_ACHK;
               else                      state_in = S_IDLE;
            end
         end
         S_ACHK: begin
            if (sts.hdr_ok) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               cmd.hdr_fail = 1'b1;
               state_in     = S_STAT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_AVER;
         end
         S_AVER: begin
            if (sts.sum_ok) begin
               cmd.emit_ans = 1'b1;
               state_in     = S_FETCH;
            end else begin
               cmd.sum_fail = 1'b1;
               state_in     = S_STAT;
            end
         end
         S_FETCH: state_in = S_EMIT;
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = sts.emit_final ? S_IDLE : S_FETCH;
            end
         end
         S_STAT: begin
            if (sts.out_free) begin
               cmd.stat_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ===== design/sbpf_datapath.sv =====
// Datapath: request and answer stores, length ring, checksum scan, result register.
// Depends on sbpf_pkg.
`default_nettype none

module sbpf_datapath #(
   parameter int MAX_PACKET  = 64,
   parameter int QUEUE_DEPTH = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sbpf_pkg::cfg_type            cfg,
   input  sbpf_pkg::cmd_type            cmd,
   output sbpf_pkg::sts_type            sts,
   input  logic [1:0]                   req_operation,
   input  logic [sbpf_pkg::BYTE_W-1:0]  req_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [sbpf_pkg::BYTE_W-1:0]  rsp_data,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_last_res,
   output logic                         rsp_answer_pending
);
   import sbpf_pkg::*;

   localparam int AW = $clog2(MAX_PACKET);
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [LEN_W-1:0] REQ_LIM = LEN_W'(MAX_PACKET - 5);
   localparam logic [LEN_W-1:0] PKT_MAX = LEN_W'(MAX_PACKET);
   localparam logic [QW-1:0]    Q_LAST  = QW'(QUEUE_DEPTH - 1);
   localparam logic [LEN_W-1:0] L0 = 7'd0, L1 = 7'd1, L2 = 7'd2, L3 = 7'd3;
   localparam logic [LEN_W-1:0] L4 = 7'd4, L5 = 7'd5, L6 = 7'd6, L7 = 7'd7;

   op_type op;
   assign op = op_type'(req_operation);

   // stores
   logic [BYTE_W-1:0] req_mem [MAX_PACKET];
   logic [BYTE_W-1:0] ans_mem [MAX_PACKET];
   logic [BYTE_W-1:0] req_rdata_ff, ans_rdata_ff;
   logic [AW-1:0]     req_raddr, ans_raddr;

   // request collection
   logic [LEN_W-1:0]  req_cnt_ff, req_cnt_in;
   logic [BYTE_W-1:0] req_xor_ff, req_xor_in;
   logic              req_blk_ff, req_blk_in;
   logic              req_spd_ff, req_spd_in;
   logic [2:0]        req_ph5_ff, req_ph5_in;
   logic [BYTE_W-1:0] req_addr_ff, req_addr_in;
   logic [BYTE_W-1:0] req_cmd_ff, req_cmd_in;
   logic [BYTE_W-1:0] req_d1_ff, req_d1_in;

   // answer collection and length ring
   logic [BYTE_W-1:0] ansb_ff [FIX_N];
   logic [LEN_W-1:0]  ans_cnt_ff, ans_cnt_in;
   logic [LEN_W-1:0]  alen_ff, alen_in;
   logic [LEN_W-1:0]  lens_ff [QUEUE_DEPTH];
   logic [QW-1:0]     rd_slot_ff, rd_slot_in, wr_slot_ff, wr_slot_in;

   // scan and emission
   logic [LEN_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              scan_vld_ff, scan_vld_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [BYTE_W-1:0] fix_ff [FIX_N];
   logic [LEN_W-1:0]  req_end_ff, req_end_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic              mode_ans_ff, mode_ans_in;
   status_type        stat_ff, stat_in;

   // result register
   logic              out_vld_ff, out_vld_in;
   logic [1:0]        out_kind_ff;
   logic [BYTE_W-1:0] out_data_ff;
   logic [2:0]        out_stat_ff;
   logic              out_last_ff, out_pend_ff;

   // ---- request byte ----
   logic              req_wr, req_data_wr, spd_hit, is_read;
   logic [LEN_W-1:0]  data_i, cnt_n, dsize;
   logic [BYTE_W-1:0] xor_n, addr_n, cmd_n, d1_n, addr_e, cmd_e, d1_e, size8, c1, c2;
   logic              blk_n, spd_n;
   logic [2:0]        ph5_n;
   logic [8:0]        sum9;
   logic [LEN_W-1:0]  qlen;

   assign req_wr      = req_cnt_ff < REQ_LIM;
   assign req_data_wr = req_wr && (req_cnt_ff >= L2);
   assign data_i      = req_cnt_ff - L2;
   assign spd_hit     = req_data_wr && req_value[1] &&
                        (((req_cmd_ff == SPEED_CMD_A) && (req_ph5_ff == 3'd2)) ||
                         ((req_cmd_ff == SPEED_CMD_B) && (data_i[1:0] == 2'd3)));
   assign cnt_n  = req_wr ? req_cnt_ff + L1 : req_cnt_ff;
   assign blk_n  = req_blk_ff || !req_wr;
   assign spd_n  = req_spd_ff || spd_hit;
   assign xor_n  = req_data_wr ? (req_xor_ff ^ req_value) : req_xor_ff;
   assign addr_n = (req_wr && (req_cnt_ff == L0)) ? req_value : req_addr_ff;
   assign cmd_n  = (req_wr && (req_cnt_ff == L1)) ? req_value : req_cmd_ff;
   assign d1_n   = (req_wr && (req_cnt_ff == L3)) ? req_value : req_d1_ff;
   assign ph5_n  = !req_data_wr ? req_ph5_ff : ((req_ph5_ff == 3'd4) ? 3'd0 : req_ph5_ff + 3'd1);

   assign addr_e = (cnt_n >= L1) ? addr_n : '0;
   assign cmd_e  = (cnt_n >= L2) ? cmd_n : '0;
   assign d1_e   = (cnt_n >= L4) ? d1_n : '0;
   assign dsize  = (cnt_n > L2) ? cnt_n - L2 : L0;
   assign size8  = BYTE_W'(dsize + L7);
   assign c1     = (size8 ^ addr_e ^ cmd_e ^ xor_n) & cfg.check_mask;
   assign c2     = (~c1) & cfg.check_mask;
   assign is_read = (cnt_n >= L2) && ((cmd_e == cfg.status_code) ||
                    (cmd_e == cfg.eeprom_read_code) || (cmd_e == cfg.ram_read_code));
   assign sum9   = {1'b0, d1_e} + READ_EXTRA;
   assign qlen   = (cmd_e == cfg.status_code) ? STATUS_LEN :
                   ((sum9 > {2'b00, LEN_SAT}) ? LEN_SAT : sum9[LEN_W-1:0]);

   // ---- bus byte ----
   logic [LEN_W-1:0] head, acnt_n;
   logic             head_nz, ans_wr, ans_full, ans_over;

   assign head     = lens_ff[rd_slot_ff];
   assign head_nz  = (head != L0);
   assign ans_wr   = ans_cnt_ff < PKT_MAX;
   assign acnt_n   = ans_wr ? ans_cnt_ff + L1 : ans_cnt_ff;
   assign ans_full = acnt_n >= head;
   assign ans_over = acnt_n >= PKT_MAX;

   logic go_stat, go_emit, go_achk, acc_go;
   logic clear_all, push, pop;

   assign go_emit = (op == OP_REQ) && req_last && !blk_n && !spd_n;
   assign go_achk = (op == OP_BUS) && head_nz && ans_full;
   assign go_stat = ((op == OP_REQ) && req_last && (blk_n || spd_n)) ||
                    ((op == OP_BUS) && head_nz && !ans_full && ans_over) ||
                    ((op == OP_ABORT) && head_nz);
   assign acc_go    = cmd.accept;
   assign clear_all = acc_go && (op == OP_CLEAR);
   assign push      = acc_go && go_emit && is_read;
   assign pop       = acc_go && (go_achk || ((op == OP_BUS) && head_nz && ans_over && !ans_full) ||
                                 ((op == OP_ABORT) && head_nz));

   // ---- scan ----
   logic             scan_issue, scan_more;
   logic [BYTE_W-1:0] chk1;

   assign scan_more  = scan_idx_ff < alen_ff;
   assign scan_issue = cmd.scan_step && scan_more;
   assign chk1       = acc_ff & cfg.check_mask;

   // ---- emission ----
   logic [BYTE_W-1:0] emit_byte;
   logic              emit_last, emit_done, out_free;

   // emit_last is the flag sent with the byte; emit_done ends the run (a packet with
   // no data flags both check bytes, but the run ends on the second one)
   always_comb begin
      if (pos_ff < L7) begin
         emit_byte = mode_ans_ff ? ansb_ff[pos_ff[2:0]] : fix_ff[pos_ff[2:0]];
      end else begin
         emit_byte = mode_ans_ff ? ans_rdata_ff : req_rdata_ff;
      end
      if (mode_ans_ff) begin
         emit_last = ((pos_ff == L4) && (alen_ff <= L7)) ||
                     ((pos_ff >= L7) && (pos_ff + L1 == alen_ff));
         emit_done = emit_last;
      end else begin
         emit_last = (((pos_ff == L5) || (pos_ff == L6)) && (req_end_ff == L7)) ||
                     ((pos_ff >= L7) && (pos_ff + L1 == req_end_ff));
         emit_done = ((pos_ff == L6) && (req_end_ff == L7)) ||
                     ((pos_ff >= L7) && (pos_ff + L1 == req_end_ff));
      end
   end

   assign out_free = !out_vld_ff || !rsp_stall;

   assign req_raddr = (pos_ff >= L7) ? AW'(pos_ff - L5) : '0;
   assign ans_raddr = scan_issue ? AW'(scan_idx_ff) : ((pos_ff >= L7) ? AW'(pos_ff) : '0);

   always_ff @(posedge clock) begin
      if (acc_go && (op == OP_REQ) && req_wr) req_mem[AW'(req_cnt_ff)] <= req_value;
      if (acc_go && (op == OP_BUS) && head_nz && ans_wr) ans_mem[AW'(ans_cnt_ff)] <= req_value;
      req_rdata_ff <= req_mem[req_raddr];
      ans_rdata_ff <= ans_mem[ans_raddr];
   end

   // ---- next-state logic ----
   always_comb begin
      req_cnt_in  = req_cnt_ff;
      req_xor_in  = req_xor_ff;
      req_blk_in  = req_blk_ff;
      req_spd_in  = req_spd_ff;
      req_ph5_in  = req_ph5_ff;
      req_addr_in = req_addr_ff;
      req_cmd_in  = req_cmd_ff;
      req_d1_in   = req_d1_ff;
      if (acc_go && (op == OP_REQ)) begin
         req_addr_in = addr_n;
         req_cmd_in  = cmd_n;
         req_d1_in   = d1_n;
         if (req_last) begin
            req_cnt_in = L0;
            req_xor_in = '0;
            req_blk_in = 1'b0;
            req_spd_in = 1'b0;
            req_ph5_in = 3'd0;
         end else begin
            req_cnt_in = cnt_n;
            req_xor_in = xor_n;
            req_blk_in = blk_n;
            req_spd_in = spd_n;
            req_ph5_in = ph5_n;
         end
      end else if (clear_all) begin
         req_cnt_in = L0;
         req_xor_in = '0;
         req_blk_in = 1'b0;
         req_spd_in = 1'b0;
         req_ph5_in = 3'd0;
      end

      ans_cnt_in = ans_cnt_ff;
      if (clear_all || pop) ans_cnt_in = L0;
      else if (acc_go && (op == OP_BUS) && head_nz) ans_cnt_in = acnt_n;

      alen_in = (acc_go && go_achk) ? head : alen_ff;

      rd_slot_in = rd_slot_ff;
      if (clear_all) rd_slot_in = '0;
      else if (pop) rd_slot_in = (rd_slot_ff == Q_LAST) ? '0 : rd_slot_ff + QW'(1);
      wr_slot_in = wr_slot_ff;
      if (clear_all) wr_slot_in = '0;
      else if (push) wr_slot_in = (wr_slot_ff == Q_LAST) ? '0 : wr_slot_ff + QW'(1);

      scan_idx_in = scan_idx_ff;
      scan_vld_in = scan_vld_ff;
      acc_in      = acc_ff;
      if (cmd.scan_init) begin
         scan_idx_in = L7;
         scan_vld_in = 1'b0;
         acc_in      = ansb_ff[2] ^ ansb_ff[3] ^ ansb_ff[4];
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_issue ? scan_idx_ff + L1 : scan_idx_ff;
         scan_vld_in = scan_issue;
         if (scan_vld_ff) acc_in = acc_ff ^ ans_rdata_ff;
      end

      req_end_in  = (acc_go && go_emit) ? dsize + L7 : req_end_ff;
      pos_in      = pos_ff;
      mode_ans_in = mode_ans_ff;
      if (acc_go && go_emit) begin
         pos_in      = L0;
         mode_ans_in = 1'b0;
      end else if (cmd.emit_ans) begin
         pos_in      = L3;
         mode_ans_in = 1'b1;
      end else if (cmd.emit_load) begin
         pos_in = (mode_ans_ff && (pos_ff == L4)) ? L7 : pos_ff + L1;
      end

      stat_in = stat_ff;
      if (acc_go) begin
         unique case (op)
            OP_REQ:   stat_in = blk_n ? ST_TOO_LONG : ST_SPEED;
            OP_BUS:   stat_in = ST_TOO_LONG;
            OP_ABORT: stat_in = ST_ABORTED;
            OP_CLEAR: stat_in = stat_ff;
         endcase
      end else if (cmd.hdr_fail) begin
         stat_in = ST_BAD_HEADER;
      end else if (cmd.sum_fail) begin
         stat_in = ST_BAD_SUM;
      end

      out_vld_in = (cmd.emit_load || cmd.stat_load) ? 1'b1 : (out_vld_ff && rsp_stall);
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         req_cnt_ff  <= L0;
         req_xor_ff  <= '0;
         req_blk_ff  <= 1'b0;
         req_spd_ff  <= 1'b0;
         req_ph5_ff  <= 3'd0;
         ans_cnt_ff  <= L0;
         rd_slot_ff  <= '0;
         wr_slot_ff  <= '0;
         scan_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         req_cnt_ff  <= req_cnt_in;
         req_xor_ff  <= req_xor_in;
         req_blk_ff  <= req_blk_in;
         req_spd_ff  <= req_spd_in;
         req_ph5_ff  <= req_ph5_in;
         ans_cnt_ff  <= ans_cnt_in;
         rd_slot_ff  <= rd_slot_in;
         wr_slot_ff  <= wr_slot_in;
         scan_vld_ff <= scan_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (reset || clear_all) begin
            lens_ff[k] <= L0;
         end else if (push && (wr_slot_ff == QW'(k))) begin
            lens_ff[k] <= qlen;
         end else if (pop && (rd_slot_ff == QW'(k))) begin
            lens_ff[k] <= L0;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_addr_ff <= req_addr_in;
      req_cmd_ff  <= req_cmd_in;
      req_d1_ff   <= req_d1_in;
      alen_ff     <= alen_in;
      scan_idx_ff <= scan_idx_in;
      acc_ff      <= acc_in;
      req_end_ff  <= req_end_in;
      pos_ff      <= pos_in;
      mode_ans_ff <= mode_ans_in;
      stat_ff     <= stat_in;
      if (acc_go && (op == OP_BUS) && head_nz && (ans_cnt_ff < L7)) begin
         ansb_ff[ans_cnt_ff[2:0]] <= req_value;
      end
      if (acc_go && go_emit) begin
         fix_ff[0] <= cfg.header_byte;
         fix_ff[1] <= cfg.header_byte;
         fix_ff[2] <= size8;
         fix_ff[3] <= addr_e;
         fix_ff[4] <= cmd_e;
         fix_ff[5] <= c1;
         fix_ff[6] <= c2;
      end
      if (cmd.emit_load) begin
         out_kind_ff <= mode_ans_ff ? KIND_ANSWER : KIND_SEND;
         out_data_ff <= emit_byte;
         out_stat_ff <= ST_OK;
         out_last_ff <= emit_last;
         out_pend_ff <= head_nz;
      end else if (cmd.stat_load) begin
         out_kind_ff <= KIND_STATUS;
         out_data_ff <= '0;
         out_stat_ff <= stat_ff;
         out_last_ff <= 1'b1;
         out_pend_ff <= head_nz;
      end
   end

   always_comb begin
      sts.go_stat    = go_stat;
      sts.go_emit    = go_emit;
      sts.go_achk    = go_achk;
      sts.hdr_ok     = (ansb_ff[0] == cfg.header_byte) && (ansb_ff[1] == cfg.header_byte) &&
                       (ansb_ff[2] == {1'b0, alen_ff});
      sts.scan_done  = !scan_more && !scan_vld_ff;
      sts.sum_ok     = (ansb_ff[5] == chk1) && (ansb_ff[6] == ((~chk1) & cfg.check_mask));
      sts.emit_final = emit_done;
      sts.out_free   = out_free;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_data           = out_data_ff;
   assign rsp_status         = out_stat_ff;
   assign rsp_last_res       = out_last_ff;
   assign rsp_answer_pending = out_pend_ff;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench of the servo bus packet framer: directed rows, then random request and answer
// sequences, all checked against a predictor in this file. Uses sbpf_pkg and the framer.
module tb;
   import sbpf_pkg::*;

   // one result transaction as it leaves the block
   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic [2:0] status;
      logic       last_res;
      logic       pend;
   } frame_rsp_type;

   // directed row; typed rows carry the one status event they must produce
   typedef struct {
      op_type     op;
      logic [7:0] v;
      logic       l;
      logic       typed;
      status_type st;
   } dir_row_type;

   localparam int MAX_PKT  = 64;
   localparam int RING_N   = 10;
   localparam int SETTLE   = 200;   // longest packet plus checksum scan, with margin
   localparam int WD_LIMIT = 5000;  // cycles with no transaction on either channel

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = OP_REQ;
   logic [7:0] req_value = 8'h00;
   logic       req_last = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic [2:0] rsp_status;
   logic       rsp_last_res;
   logic       rsp_answer_pending;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   servo_bus_packet_framer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_data(rsp_data), .rsp_status(rsp_status), .rsp_last_res(rsp_last_res),
      .rsp_answer_pending(rsp_answer_pending),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Predictor state: register copy, request collector, answer buffer, length ring.
   // ---------------------------------------------------------------------------------
   cfg_type    cfg_m;
   logic [7:0] pkt_buf [MAX_PKT];
   int         pkt_cnt;
   logic [7:0] pkt_xor;
   logic       pkt_over;
   logic [7:0] ans_buf [MAX_PKT];
   int         ans_cnt;
   int         ans_len [RING_N];
   int         rd_slot, wr_slot;

   frame_rsp_type step_buf[$];     // results of the transaction being predicted
   frame_rsp_type framer_out_q[$]; // results still owed by the block

   int errors = 0;
   int n_items = 0;
   int send_idle = 0, recv_idle = 0;
   int quiet_cycles = 0;

   function automatic void model_emit(logic [1:0] k, logic [7:0] d, logic [2:0] s,
                                      logic lr);
      frame_rsp_type r;
      r.kind = k; r.data = d; r.status = s; r.last_res = lr; r.pend = 1'b0;
      step_buf.push_back(r);
   endfunction

   function automatic void model_drop_request();
      pkt_cnt = 0;
      pkt_xor = 8'h00;
      pkt_over = 1'b0;
   endfunction

   function automatic void model_pop_answer();
      ans_len[rd_slot] = 0;
      rd_slot = (rd_slot + 1) % RING_N;
      ans_cnt = 0;
   endfunction

   // frame the collected request, or refuse it with one status event
   function automatic void model_frame_request();
      logic [7:0] cmd, addr, c1, c2, sz;
      int dsize, stride, len;
      cmd = pkt_cnt >= 2 ? pkt_buf[1] : 8'h00;
      addr = pkt_cnt >= 1 ? pkt_buf[0] : 8'h00;
      dsize = pkt_cnt > 2 ? pkt_cnt - 2 : 0;
      if (pkt_over) begin
         model_emit(KIND_STATUS, 8'h00, ST_TOO_LONG, 1'b1);
         model_drop_request();
         return;
      end
      // speed requests: every control byte must have bit 1 clear
      if (cmd == SPEED_CMD_A || cmd == SPEED_CMD_B) begin
         stride = cmd == SPEED_CMD_A ? 5 : 4;
         for (int i = (cmd == SPEED_CMD_A ? 2 : 3); i < dsize; i += stride) begin
            if (pkt_buf[i + 2][1]) begin
               model_emit(KIND_STATUS, 8'h00, ST_SPEED, 1'b1);
               model_drop_request();
               return;
            end
         end
      end
      sz = 8'(FIX_N + dsize);
      c1 = (sz ^ addr ^ cmd ^ pkt_xor) & cfg_m.check_mask;
      c2 = ~c1 & cfg_m.check_mask;
      model_emit(KIND_SEND, cfg_m.header_byte, ST_OK, 1'b0);
      model_emit(KIND_SEND, cfg_m.header_byte, ST_OK, 1'b0);
      model_emit(KIND_SEND, sz, ST_OK, 1'b0);
      model_emit(KIND_SEND, addr, ST_OK, 1'b0);
      model_emit(KIND_SEND, cmd, ST_OK, 1'b0);
      model_emit(KIND_SEND, c1, ST_OK, dsize == 0);
      model_emit(KIND_SEND, c2, ST_OK, dsize == 0);
      for (int i = 0; i < dsize; i++)
         model_emit(KIND_SEND, pkt_buf[i + 2], ST_OK, i + 1 == dsize);
      // reads queue the length of their answer; status code wins over the others
      if (pkt_cnt >= 2 && (cmd == cfg_m.status_code || cmd == cfg_m.eeprom_read_code ||
                           cmd == cfg_m.ram_read_code)) begin
         if (cmd == cfg_m.status_code) len = 9;
         else len = (dsize >= 2 ? int'(pkt_buf[3]) : 0) + 11;
         if (len > 127) len = 127;
         ans_len[wr_slot] = len;
         wr_slot = (wr_slot + 1) % RING_N;
      end
      model_drop_request();
   endfunction

   function automatic void model_check_answer(int len);
      logic [7:0] c1;
      if (ans_buf[0] != cfg_m.header_byte || ans_buf[1] != cfg_m.header_byte ||
          int'(ans_buf[2]) != len) begin
         model_emit(KIND_STATUS, 8'h00, ST_BAD_HEADER, 1'b1);
         return;
      end
      c1 = ans_buf[2] ^ ans_buf[3] ^ ans_buf[4];
      for (int i = 7; i < len; i++) c1 ^= ans_buf[i];
      c1 &= cfg_m.check_mask;
      if (ans_buf[5] != c1 || ans_buf[6] != (~c1 & cfg_m.check_mask)) begin
         model_emit(KIND_STATUS, 8'h00, ST_BAD_SUM, 1'b1);
         return;
      end
      model_emit(KIND_ANSWER, ans_buf[3], ST_OK, 1'b0);
      model_emit(KIND_ANSWER, ans_buf[4], ST_OK, len <= 7);
      for (int i = 7; i < len; i++)
         model_emit(KIND_ANSWER, ans_buf[i], ST_OK, i + 1 == len);
   endfunction

   // advance the predictor by one request transaction; results land in step_buf
   function automatic void framer_model_step(op_type op, logic [7:0] v, logic l);
      int len;
      step_buf.delete();
      case (op)
         OP_REQ: begin
            if (pkt_cnt < MAX_PKT - 5) begin
               pkt_buf[pkt_cnt] = v;
               if (pkt_cnt >= 2) pkt_xor ^= v;
               pkt_cnt++;
            end else begin
               pkt_over = 1'b1;
            end
            if (l) model_frame_request();
         end
         OP_BUS: begin
            len = ans_len[rd_slot];
            if (len != 0) begin
               if (ans_cnt < MAX_PKT) begin
                  ans_buf[ans_cnt] = v;
                  ans_cnt++;
               end
               if (ans_cnt >= len) begin
                  model_check_answer(len);
                  model_pop_answer();
               end else if (ans_cnt >= MAX_PKT) begin
                  model_emit(KIND_STATUS, 8'h00, ST_TOO_LONG, 1'b1);
                  model_pop_answer();
               end
            end
         end
         OP_ABORT: begin
            if (ans_len[rd_slot] != 0) begin
               model_emit(KIND_STATUS, 8'h00, ST_ABORTED, 1'b1);
               model_pop_answer();
            end
         end
         default: begin
            for (int i = 0; i < RING_N; i++) ans_len[i] = 0;
            rd_slot = 0;
            wr_slot = 0;
            ans_cnt = 0;
            model_drop_request();
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side. A transaction is accepted at the edge where valid is high and stall
   // low; both are read before the block's registers move.
   // ---------------------------------------------------------------------------------
   task automatic drive_byte(op_type op, logic [7:0] v, logic l,
                             logic typed = 1'b0, status_type st = ST_OK);
      frame_rsp_type r;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= v;
      req_last <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      framer_model_step(op, v, l);
      if (typed) begin
         // refusals and aborts: the single event is known up front
         step_buf.delete();
         r.kind = KIND_STATUS; r.data = 8'h00; r.status = st; r.last_res = 1'b1;
         step_buf.push_back(r);
      end
      foreach (step_buf[i]) begin
         r = step_buf[i];
         r.pend = ans_len[rd_slot] != 0;
         framer_out_q.push_back(r);
      end
      n_items++;
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain everything owed, then give the block time to finish silent work
   task automatic settle();
      release_req();
      while (framer_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // two-phase register write; pready is tied high
   task automatic csr_write(reg_index_type idx, logic [7:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= {24'h0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_HEADER: cfg_m.header_byte = v;
         REG_MASK:   cfg_m.check_mask = v;
         REG_EEPROM: cfg_m.eeprom_read_code = v;
         REG_RAM:    cfg_m.ram_read_code = v;
         default:    cfg_m.status_code = v;
      endcase
   endtask

   task automatic load_cfg(logic [7:0] hdr, logic [7:0] msk, logic [7:0] ee,
                           logic [7:0] ram, logic [7:0] stat);
      settle();
      csr_write(REG_HEADER, hdr);
      csr_write(REG_MASK, msk);
      csr_write(REG_EEPROM, ee);
      csr_write(REG_RAM, ram);
      csr_write(REG_STATUS, stat);
   endtask

   // request bytes: address, command, data; last flag on the final byte
   task automatic send_request(logic [7:0] addr, logic [7:0] cmd, logic [7:0] dat[$],
                               int n_bytes);
      for (int i = 0; i < n_bytes; i++) begin
         if (i == 0) drive_byte(OP_REQ, addr, n_bytes == 1);
         else if (i == 1) drive_byte(OP_REQ, cmd, n_bytes == 2);
         else drive_byte(OP_REQ, dat[i - 2], i == n_bytes - 1);
      end
   endtask

   // feed the answer the ring head waits for
   // mode 0 clean, 1 header/size bit flipped, 2 checksum flipped, 3 cut short then aborted or cleared
   task automatic send_answer(int mode);
      logic [7:0] b [MAX_PKT];
      logic [7:0] c1;
      int len, stop;
      len = ans_len[rd_slot];
      if (len == 0) return;
      if (len > MAX_PKT) begin
         for (int i = ans_cnt; i < MAX_PKT; i++) drive_byte(OP_BUS, 8'($urandom), 1'b0);
         return;
      end
      b[0] = cfg_m.header_byte;
      b[1] = cfg_m.header_byte;
      b[2] = 8'(len);
      b[3] = 8'($urandom);
      b[4] = 8'($urandom);
      c1 = b[2] ^ b[3] ^ b[4];
      for (int i = 7; i < len; i++) begin
         b[i] = 8'($urandom);
         c1 ^= b[i];
      end
      b[5] = c1 & cfg_m.check_mask;
      b[6] = ~c1 & cfg_m.check_mask;
      if (mode == 1) b[$urandom_range(2)] ^= 8'(1 << $urandom_range(7));
      if (mode == 2) b[$urandom_range(5, 6)] ^= 8'h02;
      stop = mode == 3 ? $urandom_range(len - 1) : len;
      for (int i = ans_cnt; i < stop; i++) drive_byte(OP_BUS, b[i], 1'($urandom));
      if (mode == 3) begin
         if ($urandom_range(3) == 0) drive_byte(OP_CLEAR, 8'($urandom), 1'($urandom));
         else drive_byte(OP_ABORT, 8'($urandom), 1'($urandom));
      end
   endtask

   // one random sequence; mostly well-formed traffic with random content
   task automatic random_sequence();
      logic [7:0] dat[$];
      logic [7:0] cmd;
      int r, n, pick;
      r = $urandom_range(99);
      dat.delete();
      for (int i = 0; i < 64; i++) dat.push_back(8'($urandom));
      if (r < 40) begin
         // read request, then its answer
         pick = $urandom_range(2);
         cmd = pick == 0 ? cfg_m.status_code :
               pick == 1 ? cfg_m.eeprom_read_code : cfg_m.ram_read_code;
         dat[1] = $urandom_range(11) == 0 ? 8'($urandom) : 8'($urandom_range(8));
         n = $urandom_range(7) == 0 ? $urandom_range(1, 2) : $urandom_range(4, 6);
         send_request(8'($urandom), cmd, dat, n);
         pick = $urandom_range(9);
         send_answer(pick < 6 ? 0 : pick < 7 ? 1 : pick < 8 ? 2 : 3);
      end else if (r < 58) begin
         // plain request; now and then one longer than the store
         n = $urandom_range(15) == 0 ? $urandom_range(59, 63) : $urandom_range(1, 10);
         send_request(8'($urandom), 8'($urandom), dat, n);
      end else if (r < 72) begin
         // speed request; control bytes have bit 1 set now and then
         cmd = $urandom_range(1) ? SPEED_CMD_A : SPEED_CMD_B;
         foreach (dat[i]) if ($urandom_range(5) != 0) dat[i][1] = 1'b0;
         send_request(8'($urandom), cmd, dat, $urandom_range(2, 16));
      end else if (r < 80) begin
         drive_byte(OP_BUS, 8'($urandom), 1'($urandom));
      end else if (r < 86) begin
         drive_byte(OP_ABORT, 8'($urandom), 1'($urandom));
      end else if (r < 90) begin
         drive_byte(OP_CLEAR, 8'($urandom), 1'($urandom));
      end else begin
         drive_byte(op_type'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: random stall, check each accepted transaction against the oldest
   // expectation.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (framer_out_q.size() == 0) begin
            $error("unexpected result kind=%0d data=%0h status=%0d", rsp_kind, rsp_data,
                   rsp_status);
            errors++;
         end else begin
            e = framer_out_q.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_kind);
               errors++;
            end
            if (rsp_data !== e.data) begin
               $error("data: expected %0h, got %0h", e.data, rsp_data);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_last_res !== e.last_res) begin
               $error("last_res: expected %0d, got %0d", e.last_res, rsp_last_res);
               errors++;
            end
            if (rsp_answer_pending !== e.pend) begin
               $error("answer_pending: expected %0d, got %0d", e.pend, rsp_answer_pending);
               errors++;
            end
         end
      end
      rsp_stall <= $urandom_range(99) < recv_idle;
   end

   // watchdog: too long with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // directed rows under reset defaults (header ff, mask fe, codes 2/4/7)
   dir_row_type dir_rows [0:21] = '{
      '{OP_ABORT, 8'h00, 1'b0, 1'b0, ST_OK},       // nothing pending: no event
      '{OP_BUS,   8'hff, 1'b1, 1'b0, ST_OK},       // unexpected bus byte, discarded
      '{OP_REQ,   8'h00, 1'b0, 1'b0, ST_OK},       // status read, address 0
      '{OP_REQ,   8'h07, 1'b1, 1'b0, ST_OK},
      '{OP_BUS,   8'hff, 1'b0, 1'b0, ST_OK},       // part of an answer
      '{OP_ABORT, 8'h00, 1'b0, 1'b1, ST_ABORTED},
      '{OP_REQ,   8'hff, 1'b1, 1'b0, ST_OK},       // address only, command taken as 0
      '{OP_REQ,   8'h01, 1'b0, 1'b0, ST_OK},       // speed 0x05, control byte flagged
      '{OP_REQ,   8'h05, 1'b0, 1'b0, ST_OK},
      '{OP_REQ,   8'h00, 1'b0, 1'b0, ST_OK},
      '{OP_REQ,   8'h00, 1'b0, 1'b0, ST_OK},
      '{OP_REQ,   8'h02, 1'b1, 1'b1, ST_SPEED},
      '{OP_REQ,   8'h02, 1'b0, 1'b0, ST_OK},       // speed 0x06, control byte clean
      '{OP_REQ,   8'h06, 1'b0, 1'b0, ST_OK},
      '{OP_REQ,   8'hff, 1'b0, 1'b0, ST_OK},
      '{OP_REQ,   8'hff, 1'b0, 1'b0, ST_OK},
      '{OP_REQ,   8'hff, 1'b0, 1'b0, ST_OK},
      '{OP_REQ,   8'hfd, 1'b1, 1'b0, ST_OK},
      '{OP_REQ,   8'h03, 1'b0, 1'b0, ST_OK},       // ram read with no length byte: 11
      '{OP_REQ,   8'h04, 1'b1, 1'b0, ST_OK},
      '{OP_CLEAR, 8'h55, 1'b1, 1'b0, ST_OK},       // clear drops the queued read
      '{OP_BUS,   8'hff, 1'b0, 1'b0, ST_OK}        // and this byte is unexpected now
   };

   initial begin
      logic [7:0] dat[$];
      int base;
      cfg_m = '{header_byte: 8'hff, check_mask: 8'hfe, eeprom_read_code: 8'h02,
                ram_read_code: 8'h04, status_code: 8'h07};
      for (int i = 0; i < RING_N; i++) ans_len[i] = 0;
      rd_slot = 0;
      wr_slot = 0;
      ans_cnt = 0;
      model_drop_request();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         drive_byte(dir_rows[i].op, dir_rows[i].v, dir_rows[i].l, dir_rows[i].typed,
                    dir_rows[i].st);
      // request past the store: one too-long event
      for (int i = 0; i < 61; i++) drive_byte(OP_REQ, 8'($urandom), i == 60);
      // status read answered cleanly, then a read whose length saturates
      dat = '{8'h00, 8'hff};
      send_request(8'h01, 8'h07, dat, 2);
      send_answer(0);
      send_request(8'hfe, 8'h04, dat, 4);
      send_answer(0);

      // three traffic phases, each under its own register setting
      base = n_items;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: load_cfg(8'h00, 8'hff, 8'h00, 8'hff, 8'h80);
            1: load_cfg(8'hff, 8'h00, 8'h11, 8'h11, 8'h11);     // all read codes equal
            default: load_cfg(8'($urandom), 8'($urandom), 8'h02, 8'h09, 8'h09);
         endcase
         send_idle = ph == 0 ? 6 : ph == 1 ? 75 : 0;
         recv_idle = ph == 0 ? 75 : ph == 1 ? 6 : 0;
         while (n_items < base + 20 * (ph + 1)) random_sequence();
      end

      release_req();
      while (framer_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/sbpf_pkg.sv
design/sbpf_csr.sv
design/sbpf_ctrl.sv
design/sbpf_datapath.sv
design/servo_bus_packet_framer.sv
sim/tb.sv
